>>> hdl/csw_pkg.sv
package csw_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int COEF_W         = 18;
	localparam int POS_W          = 12;
	localparam int LEN_W          = 13;
	localparam int MODE_W         = 2;
	localparam int MAX_LENGTH     = 4096;
	localparam int COS_TABLE_BITS = 10;
	localparam int QUARTER        = 1 << COS_TABLE_BITS;
	localparam int PHASE_W        = COS_TABLE_BITS + 2;
	localparam int ROM_DEPTH      = QUARTER + 1;
	localparam int ROM_AW         = COS_TABLE_BITS + 1;
	localparam int ROM_DW         = 17;
	localparam int WEIGHT_W       = 16;
	localparam int BASE_W         = 17;
	localparam int TPROD_W        = 36;
	localparam int ACC_W          = 36;
	localparam int SPROD_W        = SAMPLE_W + COEF_W;
	localparam int NUM_W          = POS_W + PHASE_W;
	localparam int DIV_CNT_W      = 5;
	localparam int TERM_W         = 3;
	localparam int OUT_TDATA_W    = 40;
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_DATA_W     = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_AW       = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MODE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 8'd1;

	// window modes
	localparam logic [MODE_W-1:0] MODE_RECT     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HAMMING  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BLACKMAN = 2'd2;
	localparam logic [MODE_W-1:0] MODE_FLATTOP  = 2'd3;

	localparam logic [LEN_W-1:0] LEN_RESET = 13'd1024;
	localparam logic [LEN_W-1:0] LEN_MIN   = 13'd2;
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LENGTH);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [POS_W-1:0]           pos;
		logic [POS_W-1:0]           span;
		logic [MODE_W-1:0]          mode;
		logic                       last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic take;
		logic load;
	} back_stat_t;

	typedef logic [ROM_DW-1:0] rom_t [0:ROM_DEPTH-1];

	// unsigned quotient by shift and subtract, table build only
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// cos(pi/2 * i / Q) in Q16, Taylor series in Q30
	function automatic logic [ROM_DW-1:0] quarter_cos(int unsigned i);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] den;
		longint      sum;
		x    = (64'(i) * 64'd1686629713) >> COS_TABLE_BITS;
		x2   = (x * x) >> 30;
		term = 64'd1073741824;
		sum  = 64'sd1073741824;
		for (int k = 1; k <= 8; k++) begin
			den  = 64'((2 * k - 1) * (2 * k));
			term = udiv64((term * x2) >> 30, den);
			if ((k & 1) != 0) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		return ROM_DW'((64'(sum) + 64'd8192) >> 14);
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			r[i] = quarter_cos(i);
		end
		return r;
	endfunction

	// constant term a0, Q16
	function automatic logic [BASE_W-1:0] base_weight(logic [MODE_W-1:0] mode);
		logic [BASE_W-1:0] w;
		case (mode)
			MODE_RECT:     w = 17'd65536;
			MODE_HAMMING:  w = 17'd35389;
			MODE_BLACKMAN: w = 17'd27525;
			MODE_FLATTOP:  w = 17'd14128;
			default:       w = 17'd65536;
		endcase
		return w;
	endfunction

	// cosine term weights a1..a4, Q16
	function automatic logic [WEIGHT_W-1:0] term_weight(logic [MODE_W-1:0] mode,
			logic [TERM_W-1:0] k);
		logic [WEIGHT_W-1:0] w;
		w = '0;
		case (mode)
			MODE_HAMMING: begin
				if (k == 3'd1) w = 16'd30147;
			end
			MODE_BLACKMAN: begin
				if (k == 3'd1) w = 16'd32768;
				if (k == 3'd2) w = 16'd5243;
			end
			MODE_FLATTOP: begin
				if (k == 3'd1) w = 16'd27304;
				if (k == 3'd2) w = 16'd18171;
				if (k == 3'd3) w = 16'd5477;
				if (k == 3'd4) w = 16'd455;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

>>> hdl/csw_front.sv
// Config registers, frame position and end-of-frame marking.
module csw_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [csw_pkg::SAMPLE_W-1:0]         s_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [csw_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [csw_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  csw_pkg::q_stat_t                     q_stat,
	output logic                                 q_push,
	output csw_pkg::item_t                       q_item
);

	logic [csw_pkg::MODE_W-1:0] mode_q;
	logic [csw_pkg::LEN_W-1:0]  len_q;
	logic [csw_pkg::POS_W-1:0]  pos_q;
	logic [csw_pkg::POS_W-1:0]  span;
	logic                       last;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_stat.full;
	assign q_push    = s_tvalid && s_tready;

	// out-of-range lengths are clamped
	always_comb begin
		if (len_q < csw_pkg::LEN_MIN) begin
			span = csw_pkg::POS_W'(csw_pkg::LEN_MIN - 13'd1);
		end else if (len_q > csw_pkg::LEN_MAX) begin
			span = csw_pkg::POS_W'(csw_pkg::LEN_MAX - 13'd1);
		end else begin
			span = csw_pkg::POS_W'(len_q - 13'd1);
		end
	end

	// at or past the end (length shortened mid-frame) still ends the frame
	assign last = pos_q >= span;

	assign q_item.sample = $signed(s_tdata);
	assign q_item.pos    = pos_q;
	assign q_item.span   = span;
	assign q_item.mode   = mode_q;
	assign q_item.last   = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csw_pkg::MODE_HAMMING;
			len_q  <= csw_pkg::LEN_RESET;
			pos_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == csw_pkg::REG_WINDOW_MODE) begin
					mode_q <= cfg_data[csw_pkg::MODE_W-1:0];
				end
				if (cfg_index == csw_pkg::REG_FRAME_LENGTH) begin
					len_q <= cfg_data[csw_pkg::LEN_W-1:0];
				end
			end
			if (q_push) begin
				pos_q <= last ? '0 : pos_q + 12'd1;
			end
		end
	end

endmodule

>>> hdl/csw_queue.sv
// Small FIFO between front and back.
module csw_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  csw_pkg::item_t   push_item,
	input  logic             pop,
	output csw_pkg::item_t   pop_item,
	output csw_pkg::q_stat_t stat
);

	csw_pkg::item_t                 mem_q [0:csw_pkg::QUEUE_DEPTH-1];
	logic [csw_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [csw_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [csw_pkg::QUEUE_AW:0]     cnt_q;

	assign stat.full  = cnt_q == (csw_pkg::QUEUE_AW + 1)'(csw_pkg::QUEUE_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			if (push && !pop) cnt_q <= cnt_q + 3'd1;
			else if (pop && !push) cnt_q <= cnt_q - 3'd1;
		end
	end

endmodule

>>> hdl/csw_back.sv
// Phase divider, cosine-sum accumulator, sample multiply and output register.
module csw_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  csw_pkg::q_stat_t                     q_stat,
	input  csw_pkg::item_t                       q_item,
	output logic                                 q_pop,
	output csw_pkg::back_stat_t                  stat,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [csw_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                 m_tlast
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_ADDR = 3'd2;
	localparam logic [2:0] ST_MULT = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [2:0] ST_COEF = 3'd5;
	localparam logic [2:0] ST_PROD = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam csw_pkg::rom_t COS_ROM = csw_pkg::build_rom();

	logic [2:0]                             st_q;
	logic signed [csw_pkg::SAMPLE_W-1:0]    sample_q;
	logic [csw_pkg::MODE_W-1:0]             mode_q;
	logic                                   last_q;
	logic [csw_pkg::POS_W-1:0]              span_q;
	logic [csw_pkg::NUM_W-1:0]              num_q;
	logic [csw_pkg::POS_W-1:0]              rem_q;
	logic [csw_pkg::PHASE_W-1:0]            phase_q;
	logic [csw_pkg::DIV_CNT_W-1:0]          cnt_q;
	logic [csw_pkg::TERM_W-1:0]             k_q;
	logic                                   neg_q;
	logic [csw_pkg::ROM_DW-1:0]             rom_q;
	logic signed [csw_pkg::TPROD_W-1:0]     tprod_q;
	logic signed [csw_pkg::ACC_W-1:0]       acc_q;
	logic signed [csw_pkg::COEF_W-1:0]      coef_q;
	logic signed [csw_pkg::SPROD_W-1:0]     sprod_q;
	logic                                   out_valid_q;
	logic signed [csw_pkg::SAMPLE_W-1:0]    out_sample_q;
	logic signed [csw_pkg::COEF_W-1:0]      out_coef_q;
	logic                                   out_last_q;

	logic [csw_pkg::POS_W:0]                div_t;
	logic                                   div_ge;
	logic [csw_pkg::PHASE_W-1:0]            kphase;
	logic [1:0]                             quad;
	logic [csw_pkg::COS_TABLE_BITS-1:0]     frac;
	logic [csw_pkg::ROM_AW-1:0]             rom_addr;
	logic                                   neg;
	logic signed [csw_pkg::COEF_W-1:0]      cos_val;
	logic signed [csw_pkg::COEF_W-1:0]      weight_s;
	logic signed [csw_pkg::ACC_W-1:0]       acc_rnd;
	logic signed [19:0]                     coef_raw;
	logic signed [csw_pkg::COEF_W-1:0]      coef_sat;
	logic signed [csw_pkg::SPROD_W-1:0]     sprod_rnd;
	logic signed [17:0]                     smp_raw;
	logic signed [csw_pkg::SAMPLE_W-1:0]    smp_sat;
	logic                                   out_free;

	assign out_free  = !out_valid_q || m_tready;
	assign q_pop     = (st_q == ST_IDLE) && !q_stat.empty;
	assign stat.take = q_pop;
	assign stat.load = (st_q == ST_OUT) && out_free;

	// restoring division, one quotient bit per cycle
	assign div_t  = {rem_q, num_q[csw_pkg::NUM_W-1]};
	assign div_ge = div_t >= {1'b0, span_q};

	// phase of term k, then quarter-wave folding
	always_comb begin
		case (k_q)
			3'd2:    kphase = {phase_q[csw_pkg::PHASE_W-2:0], 1'b0};
			3'd3:    kphase = phase_q + {phase_q[csw_pkg::PHASE_W-2:0], 1'b0};
			3'd4:    kphase = {phase_q[csw_pkg::PHASE_W-3:0], 2'b00};
			default: kphase = phase_q;
		endcase
	end

	assign quad = kphase[csw_pkg::PHASE_W-1 -: 2];
	assign frac = kphase[csw_pkg::COS_TABLE_BITS-1:0];
	assign neg  = (quad == 2'd1) || (quad == 2'd2);

	always_comb begin
		if (quad[0]) begin
			rom_addr = csw_pkg::ROM_AW'(csw_pkg::QUARTER) - {1'b0, frac};
		end else begin
			rom_addr = {1'b0, frac};
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= COS_ROM[rom_addr];
	end

	assign cos_val  = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
	assign weight_s = $signed({2'b00, csw_pkg::term_weight(mode_q, k_q)});

	// Q32 -> Q16 half up, then clip to the coefficient range
	assign acc_rnd  = acc_q + 36'sd32768;
	assign coef_raw = acc_rnd[csw_pkg::ACC_W-1:16];
	always_comb begin
		if (coef_raw[19:17] == 3'b000 || coef_raw[19:17] == 3'b111) begin
			coef_sat = coef_raw[csw_pkg::COEF_W-1:0];
		end else if (coef_raw[19]) begin
			coef_sat = 18'sh20000;
		end else begin
			coef_sat = 18'sh1FFFF;
		end
	end

	assign sprod_rnd = sprod_q + 34'sd32768;
	assign smp_raw   = sprod_rnd[csw_pkg::SPROD_W-1:16];
	always_comb begin
		if (smp_raw[17:15] == 3'b000 || smp_raw[17:15] == 3'b111) begin
			smp_sat = smp_raw[csw_pkg::SAMPLE_W-1:0];
		end else if (smp_raw[17]) begin
			smp_sat = 16'sh8000;
		end else begin
			smp_sat = 16'sh7FFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			k_q         <= 3'd1;
			out_valid_q <= 1'b0;
		end else begin
			// a load wins over the drain of the previous result
			if ((st_q == ST_OUT) && out_free) out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						cnt_q <= '0;
						st_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == csw_pkg::DIV_CNT_W'(csw_pkg::NUM_W - 1)) begin
						k_q  <= 3'd1;
						st_q <= ST_ADDR;
					end
				end
				ST_ADDR: st_q <= ST_MULT;
				ST_MULT: st_q <= ST_ACC;
				ST_ACC: begin
					if (k_q == 3'd4) begin
						st_q <= ST_COEF;
					end else begin
						k_q  <= k_q + 3'd1;
						st_q <= ST_ADDR;
					end
				end
				ST_COEF: st_q <= ST_PROD;
				ST_PROD: st_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				sample_q <= q_item.sample;
				mode_q   <= q_item.mode;
				last_q   <= q_item.last;
				span_q   <= q_item.span;
				// numerator = pos * turn + floor(span / 2)
				num_q    <= {q_item.pos, 1'b0, q_item.span[csw_pkg::POS_W-1:1]};
				rem_q    <= '0;
			end
			ST_DIV: begin
				rem_q   <= div_ge ? csw_pkg::POS_W'(div_t - {1'b0, span_q})
				                  : div_t[csw_pkg::POS_W-1:0];
				phase_q <= {phase_q[csw_pkg::PHASE_W-2:0], div_ge};
				num_q   <= {num_q[csw_pkg::NUM_W-2:0], 1'b0};
				acc_q   <= $signed({3'b000, csw_pkg::base_weight(mode_q), 16'h0000});
			end
			ST_ADDR: neg_q <= neg;
			ST_MULT: tprod_q <= weight_s * cos_val;
			ST_ACC: begin
				// odd terms subtract, even terms add
				if (k_q[0]) acc_q <= acc_q - tprod_q;
				else acc_q <= acc_q + tprod_q;
			end
			ST_COEF: coef_q <= coef_sat;
			ST_PROD: sprod_q <= sample_q * coef_q;
			ST_OUT: begin
				if (out_free) begin
					out_sample_q <= smp_sat;
					out_coef_q   <= coef_q;
					out_last_q   <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'b000000, out_coef_q, out_sample_q};

endmodule

>>> hdl/cosine_sum_window_apply_core.sv
// Cosine-sum window applied to a sample stream. Each input transaction carries
// one signed 16-bit sample; the block counts positions 0..L-1 within a frame
// (L from the frame_length register, clamped to 2..4096) and multiplies each
// sample by the window value w(n) = a0 - a1*cos(t) + a2*cos(2t) - a3*cos(3t)
// + a4*cos(4t), t = 2*pi*n/(L-1), for rectangular, Hamming, Blackman or
// flat-top weights. Each output transaction gives the rounded, saturated
// product, the Q2.16 coefficient and tlast on the last sample of the frame.
// The back end takes one sample at a time and runs a 24-step
// restoring divider for the phase index, then four passes over the single
// quarter-wave cosine ROM (address, multiply, accumulate), then coefficient
// rounding, the sample multiply and the output load. A four-entry queue lets
// the front accept samples while the back end works, and the output register
// holds a result while the next one is computed. Config writes take effect
// on the next sample, do not reset the frame position, and are meant to be
// issued while the block is idle; unknown register indexes are ignored.
module cosine_sum_window_apply_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input samples
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [csw_pkg::SAMPLE_W-1:0]         s_tdata,   // [15:0] sample_in
	// windowed samples
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [csw_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [15:0] sample_out,
	                                                        // [33:16] coefficient
	output logic                                 m_tlast,   // frame_end
	// register writes: 0 window_mode, 1 frame_length
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [csw_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [csw_pkg::CFG_DATA_W-1:0]       cfg_data
);

	csw_pkg::q_stat_t    q_stat;
	csw_pkg::back_stat_t back_stat;
	csw_pkg::item_t      push_item;
	csw_pkg::item_t      pop_item;
	logic                q_push;
	logic                q_pop;

	// front: config, position, frame end
	csw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	// decoupling queue
	csw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	// back: phase, coefficient, product, output register
	csw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_item   (pop_item),
		.q_pop    (q_pop),
		.stat     (back_stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue push while full");

	// back only takes an item that is there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.take |-> !q_stat.empty)
		else $error("queue pop while empty");

	// a new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.load |-> (!m_tvalid || m_tready))
		else $error("output register overwritten");

endmodule
